>>> rtl/ps_pkg.sv
// ----------------------------------------------------------------------------
// ps_pkg
// Shared types for the pigeonhole sorter: request and result payloads and
// the status that the sort engine returns to the loader.
// ----------------------------------------------------------------------------
package ps_pkg;

    typedef struct packed {
        logic signed [15:0] value;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] sorted_value;
        logic               end_of_set;
        logic               error;
    } out_item_t;

    typedef struct packed {
        logic init_done;
        logic buf_release;
    } back_status_t;

endpackage

>>> rtl/pigeonhole_sorter.sv
// ----------------------------------------------------------------------------
// pigeonhole_sorter
// Counting sort of a set of signed values; results come out ascending, the
// last one marked, or as a single error result.
//
//   channel   signals                      payload
//   input     item_valid / item_ready      item   (value, last)
//   output    result_valid / result_ready  result (sorted_value, end_of_set, error)
//
// Loading takes one request per cycle while the job queue has room; after the
// marked request of a set that sorts, item_ready stays low until the engine has
// counted it out of the buffer. Per set: the job is taken, each item counted
// (buffer read, bin read, bin write), the bins walked up to the maximum with
// one result per item; an error set gives one error result. Output stalls hold
// the walk. After reset a clearing pass zeroes the bins with item_ready low.
// ----------------------------------------------------------------------------
module pigeonhole_sorter
    import ps_pkg::*;
#(
    parameter int MAX_ITEMS  = 64,
    parameter int NUM_BINS   = 1024,
    parameter int VALUE_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int JW = VALUE_BITS + CW + 1;

    logic                  buf_we;
    logic [AW-1:0]         buf_waddr;
    logic [VALUE_BITS-1:0] buf_wdata;
    logic                  job_push;
    logic [JW-1:0]         job_in;
    logic                  job_pop;
    logic [JW-1:0]         job_out;
    logic                  job_full;
    logic                  job_empty;
    back_status_t          status;

    ps_front #(
        .MAX_ITEMS  (MAX_ITEMS),
        .NUM_BINS   (NUM_BINS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .buf_we     (buf_we),
        .buf_waddr  (buf_waddr),
        .buf_wdata  (buf_wdata),
        .job_push   (job_push),
        .job_data   (job_in),
        .job_full   (job_full),
        .status     (status)
    );

    ps_job_fifo #(
        .W (JW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .pop       (job_pop),
        .pop_data  (job_out),
        .full      (job_full),
        .empty     (job_empty)
    );

    ps_back #(
        .MAX_ITEMS  (MAX_ITEMS),
        .NUM_BINS   (NUM_BINS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .buf_we       (buf_we),
        .buf_waddr    (buf_waddr),
        .buf_wdata    (buf_wdata),
        .job_pop      (job_pop),
        .job_data     (job_out),
        .job_empty    (job_empty),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

>>> rtl/ps_front.sv
// ----------------------------------------------------------------------------
// ps_front
// Loader: takes one request per cycle while ready, writes the item buffer,
// tracks min, max, count and overflow, and queues one job per set.
// ----------------------------------------------------------------------------
module ps_front
    import ps_pkg::*;
#(
    parameter int MAX_ITEMS  = 64,
    parameter int NUM_BINS   = 1024,
    parameter int VALUE_BITS = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  in_item_t                              item,
    output logic                                  buf_we,
    output logic [$clog2(MAX_ITEMS)-1:0]          buf_waddr,
    output logic [VALUE_BITS-1:0]                 buf_wdata,
    output logic                                  job_push,
    output logic [VALUE_BITS+$clog2(MAX_ITEMS+1):0] job_data,
    input  logic                                  job_full,
    input  back_status_t                          status
);

    localparam int VB = VALUE_BITS;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int SW = (VB + 2 > 18) ? VB + 2 : 18;

    logic [CW-1:0]        count_reg;
    logic signed [VB-1:0] min_reg;
    logic signed [VB-1:0] max_reg;
    logic                 ovf_reg;
    logic                 lock_reg;

    logic signed [VB-1:0] v_conv;
    logic signed [VB-1:0] min_new;
    logic signed [VB-1:0] max_new;
    logic [CW-1:0]        cnt_new;
    logic                 ovf_new;
    logic                 has_room;
    logic                 accept;
    logic signed [SW-1:0] span;
    logic                 too_wide;
    logic                 job_err;

    generate
        if (VB > 16) begin : g_wide
            assign v_conv = VB'($unsigned(item.value));
        end else begin : g_narrow
            assign v_conv = item.value[VB-1:0];
        end
    endgenerate

    assign item_ready = status.init_done && !lock_reg && !job_full;
    assign accept     = item_valid && item_ready;
    assign has_room   = (count_reg < CW'(MAX_ITEMS));

    always_comb
    begin
        min_new  = (v_conv < min_reg) ? v_conv : min_reg;
        max_new  = (v_conv > max_reg) ? v_conv : max_reg;
        cnt_new  = has_room ? CW'(count_reg + 1'b1) : count_reg;
        ovf_new  = ovf_reg || !has_room;
        span     = SW'(max_new) - SW'(min_new) + SW'(1);
        too_wide = (span > SW'(NUM_BINS));
        job_err  = ovf_new || too_wide;
    end

    assign buf_we    = accept && has_room;
    assign buf_waddr = count_reg[AW-1:0];
    assign buf_wdata = v_conv;
    assign job_push  = accept && item.last;
    assign job_data  = {job_err, cnt_new, min_new};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            min_reg   <= {1'b0, {(VB-1){1'b1}}};
            max_reg   <= {1'b1, {(VB-1){1'b0}}};
            ovf_reg   <= 1'b0;
            lock_reg  <= 1'b0;
        end
        else
        begin
            if (status.buf_release)
                lock_reg <= 1'b0;
            if (accept)
            begin
                if (item.last)
                begin
                    count_reg <= '0;
                    min_reg   <= {1'b0, {(VB-1){1'b1}}};
                    max_reg   <= {1'b1, {(VB-1){1'b0}}};
                    ovf_reg   <= 1'b0;
                    lock_reg  <= !job_err;
                end
                else
                begin
                    count_reg <= cnt_new;
                    min_reg   <= min_new;
                    max_reg   <= max_new;
                    ovf_reg   <= ovf_new;
                end
            end
        end
    end

endmodule

>>> rtl/ps_job_fifo.sv
// ----------------------------------------------------------------------------
// ps_job_fifo
// Two-entry queue of set jobs between loader and sort engine.
// ----------------------------------------------------------------------------
module ps_job_fifo
#(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         full,
    output logic         empty
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop && !empty)
                rd_ptr_reg <= !rd_ptr_reg;
            if ((push && !full) && !(pop && !empty))
                cnt_reg <= cnt_reg + 2'd1;
            else if (!(push && !full) && (pop && !empty))
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

>>> rtl/ps_back.sv
// ----------------------------------------------------------------------------
// ps_back
// Sort engine: counts buffered items into the bin store, walks the bins in
// ascending order emitting results, and clears each bin it empties.
// ----------------------------------------------------------------------------
module ps_back
    import ps_pkg::*;
#(
    parameter int MAX_ITEMS  = 64,
    parameter int NUM_BINS   = 1024,
    parameter int VALUE_BITS = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  buf_we,
    input  logic [$clog2(MAX_ITEMS)-1:0]          buf_waddr,
    input  logic [VALUE_BITS-1:0]                 buf_wdata,
    output logic                                  job_pop,
    input  logic [VALUE_BITS+$clog2(MAX_ITEMS+1):0] job_data,
    input  logic                                  job_empty,
    output back_status_t                          status,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output out_item_t                             result
);

    localparam int VB     = VALUE_BITS;
    localparam int CW     = $clog2(MAX_ITEMS + 1);
    localparam int AW     = $clog2(MAX_ITEMS);
    localparam int BIN_AW = $clog2(NUM_BINS);
    localparam int IW     = (VB > BIN_AW) ? VB : BIN_AW;
    localparam int XW     = (VB > 16) ? VB : 16;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ERR,
        S_CNT_RD,
        S_CNT_BIN,
        S_CNT_WR,
        S_W_RD,
        S_W_LOAD,
        S_W_EMIT
    } state_t;

    state_t               state_reg;
    logic signed [VB-1:0] min_reg;
    logic [CW-1:0]        total_reg;
    logic [CW-1:0]        ptr_reg;
    logic [CW-1:0]        rem_reg;
    logic [CW-1:0]        cnt_reg;
    logic [BIN_AW-1:0]    walk_reg;
    logic [BIN_AW-1:0]    idx_reg;
    logic                 out_valid_reg;
    out_item_t            out_data_reg;

    logic [VB-1:0]        buf_mem [MAX_ITEMS];
    logic [VB-1:0]        buf_rd_data;
    logic [CW-1:0]        bin_mem [NUM_BINS];
    logic [CW-1:0]        bin_rd_data;

    logic [AW-1:0]        buf_raddr;
    logic [BIN_AW-1:0]    bin_raddr;
    logic                 bin_we;
    logic [BIN_AW-1:0]    bin_waddr;
    logic [CW-1:0]        bin_wdata;
    logic [IW-1:0]        diff;
    logic [BIN_AW-1:0]    idx_calc;
    logic                 slot_free;
    logic                 emit_now;
    logic                 count_done;
    logic signed [VB-1:0] emit_v;
    logic signed [XW-1:0] emit_x;

    assign slot_free  = !out_valid_reg || result_ready;
    assign emit_now   = slot_free && ((state_reg == S_ERR) || (state_reg == S_W_EMIT));
    assign count_done = (CW'(ptr_reg + 1'b1) == total_reg);
    assign job_pop    = (state_reg == S_IDLE) && !job_empty;
    assign buf_raddr  = ptr_reg[AW-1:0];

    assign status.init_done   = (state_reg != S_CLEAR);
    assign status.buf_release = (state_reg == S_CNT_WR) && count_done;

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    always_comb
    begin
        diff      = IW'($signed(buf_rd_data)) - IW'(min_reg);
        idx_calc  = diff[BIN_AW-1:0];
        emit_v    = min_reg + VB'(walk_reg);
        emit_x    = XW'(emit_v);
        bin_raddr = (state_reg == S_CNT_BIN) ? idx_calc : walk_reg;
        bin_we    = 1'b0;
        bin_waddr = walk_reg;
        bin_wdata = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                bin_we = 1'b1;
            end
            S_CNT_WR:
            begin
                bin_we    = 1'b1;
                bin_waddr = idx_reg;
                bin_wdata = CW'(bin_rd_data + 1'b1);
            end
            S_W_EMIT:
            begin
                bin_we = slot_free && (cnt_reg == CW'(1));
            end
            default:
            begin
                bin_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
            buf_mem[buf_waddr] <= buf_wdata;
        buf_rd_data <= buf_mem[buf_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (bin_we)
            bin_mem[bin_waddr] <= bin_wdata;
        bin_rd_data <= bin_mem[bin_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            min_reg       <= '0;
            idx_reg       <= '0;
            walk_reg      <= '0;
            ptr_reg       <= '0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= emit_now || (out_valid_reg && !result_ready);
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (walk_reg == BIN_AW'(NUM_BINS - 1))
                    begin
                        walk_reg  <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                        walk_reg <= walk_reg + 1'b1;
                end
                S_IDLE:
                begin
                    if (!job_empty)
                    begin
                        min_reg   <= job_data[VB-1:0];
                        total_reg <= job_data[VB+CW-1:VB];
                        ptr_reg   <= '0;
                        walk_reg  <= '0;
                        state_reg <= job_data[VB+CW] ? S_ERR : S_CNT_RD;
                    end
                end
                S_ERR:
                begin
                    if (slot_free)
                    begin
                        out_data_reg.sorted_value <= '0;
                        out_data_reg.end_of_set   <= 1'b1;
                        out_data_reg.error        <= 1'b1;
                        state_reg                 <= S_IDLE;
                    end
                end
                S_CNT_RD:
                begin
                    state_reg <= S_CNT_BIN;
                end
                S_CNT_BIN:
                begin
                    idx_reg   <= idx_calc;
                    state_reg <= S_CNT_WR;
                end
                S_CNT_WR:
                begin
                    ptr_reg <= CW'(ptr_reg + 1'b1);
                    if (count_done)
                    begin
                        rem_reg   <= total_reg;
                        state_reg <= S_W_RD;
                    end
                    else
                        state_reg <= S_CNT_RD;
                end
                S_W_RD:
                begin
                    state_reg <= S_W_LOAD;
                end
                S_W_LOAD:
                begin
                    cnt_reg <= bin_rd_data;
                    if (bin_rd_data == '0)
                    begin
                        walk_reg  <= walk_reg + 1'b1;
                        state_reg <= S_W_RD;
                    end
                    else
                        state_reg <= S_W_EMIT;
                end
                S_W_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_data_reg.sorted_value <= emit_x[15:0];
                        out_data_reg.end_of_set   <= (rem_reg == CW'(1));
                        out_data_reg.error        <= 1'b0;
                        cnt_reg                   <= cnt_reg - 1'b1;
                        rem_reg                   <= rem_reg - 1'b1;
                        if (cnt_reg == CW'(1))
                        begin
                            walk_reg  <= walk_reg + 1'b1;
                            state_reg <= (rem_reg == CW'(1)) ? S_IDLE : S_W_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> verif/pigeonhole_sorter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pigeonhole_sorter_tb
// Self-checking bench for the pigeonhole sorter. Sets of signed values are
// streamed in with random bursts and gaps. A local model takes every accepted
// request and rebuilds each sorted run, or the lone error result, on the
// marked one. The result side stalls on its own shifting pattern. Each result
// is compared field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module pigeonhole_sorter_tb;
    import ps_pkg::*;

    localparam int SET_CAP       = 64;
    localparam int BIN_COUNT     = 1024;
    localparam int SETTLE_CYCLES = 3 * SET_CAP + 2 * BIN_COUNT + SET_CAP + 16;
    localparam int HOLD_CYCLES   = 3000;

    typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_ready;
    in_item_t  item;
    logic      result_valid;
    logic      result_ready;
    out_item_t result;

    // model of the set being loaded
    int        set_vals[SET_CAP];
    int        set_count    = 0;
    int        set_min      = 32767;
    int        set_max      = -32768;
    bit        set_overflow = 1'b0;
    out_item_t pending_sorted[$];

    int        mismatch_count = 0;
    int        result_count   = 0;
    int        burst_left     = 0;
    int        rx_hold_req    = 0;
    int        hold_left      = 0;
    int        rx_mode_left   = 0;
    int        rx_phase       = 0;
    rx_mode_t  rx_mode        = RX_OPEN;

    pigeonhole_sorter #(
        .MAX_ITEMS  (SET_CAP),
        .NUM_BINS   (BIN_COUNT),
        .VALUE_BITS (16)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void push_result(logic signed [15:0] v, logic eos, logic err);
        out_item_t r;
        r.sorted_value = v;
        r.end_of_set   = eos;
        r.error        = err;
        pending_sorted.insert(pending_sorted.size(), r);
    endfunction

    // load one value into the set; on the marked one, predict the run or error
    function automatic void absorb_item(logic signed [15:0] v_in, logic last_in);
        int v;
        int span;
        int i;
        int j;
        int t;
        v = v_in;
        if (set_count < SET_CAP)
        begin
            set_vals[set_count] = v;
            set_count++;
        end
        else
            set_overflow = 1'b1;
        if (v < set_min)
            set_min = v;
        if (v > set_max)
            set_max = v;
        if (!last_in)
            return;
        span = set_max - set_min + 1;
        if (set_overflow || span > BIN_COUNT)
            push_result('0, 1'b1, 1'b1);
        else
        begin
            for (i = 1; i < set_count; i++)
            begin
                t = set_vals[i];
                j = i - 1;
                while (j >= 0 && set_vals[j] > t)
                begin
                    set_vals[j + 1] = set_vals[j];
                    j--;
                end
                set_vals[j + 1] = t;
            end
            for (i = 0; i < set_count; i++)
                push_result(set_vals[i][15:0], i == set_count - 1, 1'b0);
        end
        set_count    = 0;
        set_min      = 32767;
        set_max      = -32768;
        set_overflow = 1'b0;
    endfunction

    task automatic report_mismatch(string field, logic signed [15:0] got,
                                   logic signed [15:0] want);
        mismatch_count++;
        $display("%0t result %0d: %s got %0d want %0d",
                 $time, result_count, field, got, want);
    endtask

    task automatic check_result(out_item_t got);
        out_item_t want;
        if (pending_sorted.size() == 0)
            report_mismatch("unexpected result, sorted_value", got.sorted_value, 16'sd0);
        else
        begin
            want = pending_sorted.pop_front();
            if (got.sorted_value !== want.sorted_value)
                report_mismatch("sorted_value", got.sorted_value, want.sorted_value);
            if (got.end_of_set !== want.end_of_set)
                report_mismatch("end_of_set", 16'(got.end_of_set), 16'(want.end_of_set));
            if (got.error !== want.error)
                report_mismatch("error", 16'(got.error), 16'(want.error));
        end
        result_count++;
    endtask

    // result side: checks, then picks next ready
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
                check_result(result);
            if (rx_hold_req > 0)
            begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (rx_mode_left == 0)
            begin
                rx_mode      = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(20, 200);
            end
            else
                rx_mode_left--;
            rx_phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_OPEN:     result_ready <= 1'b1;
                    RX_COIN:     result_ready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: result_ready <= (rx_phase % 4) != 0;
                    default:     result_ready <= $urandom_range(0, 7) == 0;
                endcase
            end
        end
    end

    task automatic send_item(logic signed [15:0] v, logic l);
        in_item_t req;
        int       gap;
        req.value = v;
        req.last  = l;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        item_valid <= 1'b1;
        item       <= req;
        do
            @(posedge clk);
        while (!item_ready);
        absorb_item(v, l);
    endtask

    // n values in [lo, lo + width], last one marked
    task automatic send_set(int n, int lo, int width);
        int i;
        for (i = 0; i < n; i++)
            send_item(16'(lo + int'($urandom_range(0, width))), i == n - 1);
    endtask

    task automatic wait_sets_done();
        item_valid <= 1'b0;
        while (pending_sorted.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_edge_values();
        send_item(-16'sd32768, 1'b1);
        send_item(16'sd32767, 1'b1);
        send_item(16'sd0, 1'b1);
        // span of exactly the bin store, low end
        send_item(-16'sd32768 + 16'sd1023, 1'b0);
        send_item(-16'sd32768, 1'b1);
        // duplicates
        send_item(16'sd5, 1'b0);
        send_item(-16'sd1, 1'b0);
        send_item(16'sd5, 1'b0);
        send_item(16'sd5, 1'b1);
        // span one past the bin store
        send_item(16'sd100, 1'b0);
        send_item(16'sd1124, 1'b1);
        send_item(-16'sd32768, 1'b0);
        send_item(16'sd32767, 1'b1);
        send_item(-16'sd1, 1'b0);
        send_item(16'sd0, 1'b0);
        send_item(16'sd1, 1'b0);
        send_item(-16'sd2, 1'b1);
        // span of exactly the bin store, high end
        send_item(16'sd32767, 1'b0);
        send_item(16'sd32767 - 16'sd1023, 1'b1);
        send_item(16'sh5555, 1'b0);
        send_item(16'shAAAA, 1'b1);
    endtask

    task automatic test_buffer_limit();
        send_set(SET_CAP, -40, 30);
        send_set(SET_CAP + 2, 200, 100);
        send_set(SET_CAP, 1000, 0);
    endtask

    task automatic test_random_sets(int n_items);
        int sent;
        int kind;
        int n;
        int w;
        int base;
        int i;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 80)
            begin
                n    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, SET_CAP)
                                                   : $urandom_range(1, 8);
                w    = ($urandom_range(0, 4) == 0) ? $urandom_range(64, BIN_COUNT - 1)
                                                   : $urandom_range(0, 63);
                base = $urandom_range(0, 65535 - w) - 32768;
                send_set(n, base, w);
            end
            else if (kind < 97)
            begin
                n = $urandom_range(2, 6);
                for (i = 0; i < n; i++)
                    send_item(16'($urandom_range(0, 65535)), i == n - 1);
            end
            else
            begin
                n = $urandom_range(SET_CAP + 1, SET_CAP + 4);
                send_set(n, $urandom_range(0, 200) - 100, 50);
            end
            sent += n;
        end
    endtask

    task automatic test_output_hold();
        int k;
        rx_hold_req = HOLD_CYCLES;
        for (k = 0; k < 8; k++)
            send_set($urandom_range(6, 12), $urandom_range(0, 60000) - 30000,
                     $urandom_range(0, 200));
    endtask

    task automatic test_drain_pause();
        wait_sets_done();
        send_set(3, -5, 10);
        send_set(1, 7, 0);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_edge_values();
        test_buffer_limit();
        test_random_sets(100);
        test_output_hold();
        test_drain_pause();
        test_random_sets(100);

        wait_sets_done();
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
